### rtl/core/pplsc_pkg.sv
// pplsc_pkg: shared constants and codes for the phong point light shader core
// no dependencies; imported by pplsc_isqrt and phong_point_light_shader_core
`timescale 1ns / 1ps

package pplsc_pkg;

  // fixed-point formats that do not follow the module parameters
  localparam int DIR_W      = 16;        // one Q1.14 vector component
  localparam int SHIN_W     = 10;        // whole-number specular exponent
  localparam int NORM_BITS  = 20;        // light vector magnitude after scaling
  localparam int SUMSQ_W    = 42;        // sum of three squared 20-bit magnitudes
  localparam int ROOT_W     = 21;        // integer square root of SUMSQ_W bits
  localparam int QUO_W      = 15;        // unit component quotient, up to 2^14
  localparam int POW_W      = 24;        // power term width
  localparam int LDN_W      = 34;        // light.normal dot product, Q2.28
  localparam int LDN14_W    = 20;        // non-negative dot product in Q14
  localparam int Q14_ONE    = 16384;
  localparam int LIGHT_RESET = 4096;     // 1.0 in Q4.12

  localparam logic [POW_W-1:0] POW_CAP = '1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LIGHT_POS_X = 3'd0,
    REG_LIGHT_POS_Y = 3'd1,
    REG_LIGHT_POS_Z = 3'd2,
    REG_LIGHT_RED   = 3'd3,
    REG_LIGHT_GREEN = 3'd4,
    REG_LIGHT_BLUE  = 3'd5
  } cfg_reg_e;

endpackage

### rtl/core/phong_point_light_shader_core.sv
// phong_point_light_shader_core: Phong shading of one surface point for one point light
// depends on pplsc_pkg and pplsc_isqrt
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   item     | item_valid, item_stall, point_*, ..., in_shadow | in
//   result   | result_valid, result_stall, out_red/green/blue  | out
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
// 63 register stages from accept to result; one item may enter every cycle unless the
// result is stalled. the length is set by the square root (21 stages), the unit vector
// division (15 stages) and the square-and-multiply power (10 stages).
// rst (synchronous) clears each stage valid bit and light position, sets colour to 1.0.
// a stalled result freezes the whole pipeline and holds item_stall high.
`timescale 1ns / 1ps

module phong_point_light_shader_core #(
  parameter int COORD_WIDTH  = 24,
  parameter int COLOUR_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // item channel
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [COORD_WIDTH-1:0]    point_x,
  input  logic [COORD_WIDTH-1:0]    point_y,
  input  logic [COORD_WIDTH-1:0]    point_z,
  input  logic [3*pplsc_pkg::DIR_W-1:0] eye_dir,
  input  logic [3*pplsc_pkg::DIR_W-1:0] normal_dir,
  input  logic [3*COLOUR_WIDTH-1:0] surface_colour,
  input  logic [3*COLOUR_WIDTH-1:0] material_coeffs,
  input  logic [pplsc_pkg::SHIN_W-1:0] shininess,
  input  logic                      in_shadow,
  // result channel
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [COLOUR_WIDTH-1:0]   out_red,
  output logic [COLOUR_WIDTH-1:0]   out_green,
  output logic [COLOUR_WIDTH-1:0]   out_blue,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [(COORD_WIDTH > COLOUR_WIDTH ? COORD_WIDTH : COLOUR_WIDTH)-1:0] cfg_data
);
  import pplsc_pkg::*;

  localparam int CW = COLOUR_WIDTH;
  localparam int CC = COORD_WIDTH;
  localparam int MW = CC + 1;
  localparam int PW = $clog2(MW);
  localparam logic [CW-1:0] CMAX = '1;
  localparam logic [CW-1:0] LIGHT_ONE = CW'(LIGHT_RESET);

  typedef struct packed {
    logic [3*DIR_W-1:0] nrm;
    logic [3*DIR_W-1:0] eye;
    logic [SHIN_W-1:0]  shin;
    logic               shadow;
    logic [3*CW-1:0]    amb;   // ambient term per channel
    logic [3*CW-1:0]    dtf;   // eff * kd per channel
    logic [3*CW-1:0]    ssc;   // light * ks per channel
  } tail_t;

  typedef struct packed {
    logic [2:0]             sgn;
    logic                   zero;
    logic [3*NORM_BITS-1:0] mag;
    tail_t                  tail;
  } side_t;

  typedef struct packed {
    logic               spec_on;
    logic               dif_on;
    logic [LDN14_W-1:0] ldn14;
    tail_t              tail;
  } pw_side_t;

  // fixed-point products with truncation and clamping
  function automatic logic [CW-1:0] mul_q12(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [2*CW-1:0] p;
    p = (2*CW)'(a) * (2*CW)'(b);
    p = p >> 12;
    return (p > (2*CW)'(CMAX)) ? CMAX : p[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mul_q14_d(input logic [CW-1:0] a,
                                              input logic [LDN14_W-1:0] b);
    logic [CW+LDN14_W-1:0] p;
    p = (CW+LDN14_W)'(a) * (CW+LDN14_W)'(b);
    p = p >> 14;
    return (p > (CW+LDN14_W)'(CMAX)) ? CMAX : p[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mul_q14_s(input logic [CW-1:0] a,
                                              input logic [POW_W-1:0] b);
    logic [CW+POW_W-1:0] p;
    p = (CW+POW_W)'(a) * (CW+POW_W)'(b);
    p = p >> 14;
    return (p > (CW+POW_W)'(CMAX)) ? CMAX : p[CW-1:0];
  endfunction

  function automatic logic [POW_W-1:0] pow_mul(input logic [POW_W-1:0] a,
                                               input logic [POW_W-1:0] b);
    logic [2*POW_W-1:0] p;
    p = (2*POW_W)'(a) * (2*POW_W)'(b);
    p = p >> 14;
    return (p > (2*POW_W)'(POW_CAP)) ? POW_CAP : p[POW_W-1:0];
  endfunction

  // pipeline advance: everything moves unless the result is held
  logic adv;
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // light registers
  logic [CC-1:0] lp [3];
  logic [CW-1:0] lc [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        lp[i] <= '0;
        lc[i] <= LIGHT_ONE;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIGHT_POS_X: lp[0] <= cfg_data[CC-1:0];
        REG_LIGHT_POS_Y: lp[1] <= cfg_data[CC-1:0];
        REG_LIGHT_POS_Z: lp[2] <= cfg_data[CC-1:0];
        REG_LIGHT_RED:   lc[0] <= cfg_data[CW-1:0];
        REG_LIGHT_GREEN: lc[1] <= cfg_data[CW-1:0];
        REG_LIGHT_BLUE:  lc[2] <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: accepted item
  logic               v1;
  logic [CC-1:0]      pt1 [3];
  logic [3*DIR_W-1:0] eye1, nrm1;
  logic [3*CW-1:0]    col1, coef1;
  logic [SHIN_W-1:0]  shin1;
  logic               shadow1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt1[0]  <= point_x;
      pt1[1]  <= point_y;
      pt1[2]  <= point_z;
      eye1    <= eye_dir;
      nrm1    <= normal_dir;
      col1    <= surface_colour;
      coef1   <= material_coeffs;
      shin1   <= shininess;
      shadow1 <= in_shadow;
    end
  end

  // stage 2: light vector as sign and magnitude, effective colour, specular scale
  logic signed [MW-1:0] dd [3];
  logic               v2;
  logic [MW-1:0]      m2 [3];
  logic [2:0]         sg2;
  logic [CW-1:0]      eff2 [3];
  logic [CW-1:0]      ss2 [3];
  logic [CW-1:0]      ka2, kd2;
  logic [3*DIR_W-1:0] eye2, nrm2;
  logic [SHIN_W-1:0]  shin2;
  logic               shadow2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = $signed({lp[i][CC-1], lp[i]}) - $signed({pt1[i][CC-1], pt1[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sg2[i]  <= dd[i][MW-1];
        m2[i]   <= dd[i][MW-1] ? MW'(-dd[i]) : MW'(dd[i]);
        eff2[i] <= mul_q12(col1[CW*i +: CW], lc[i]);
        ss2[i]  <= mul_q12(lc[i], coef1[2*CW +: CW]);
      end
      ka2     <= coef1[0 +: CW];
      kd2     <= coef1[CW +: CW];
      eye2    <= eye1;
      nrm2    <= nrm1;
      shin2   <= shin1;
      shadow2 <= shadow1;
    end
  end

  // stage 3: largest magnitude, ambient and diffuse colour factors
  logic               v3;
  logic [MW-1:0]      m3 [3];
  logic [MW-1:0]      mx3;
  logic [2:0]         sg3;
  tail_t              tl3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3  <= m2;
      sg3 <= sg2;
      if (m2[0] >= m2[1] && m2[0] >= m2[2]) begin
        mx3 <= m2[0];
      end else if (m2[1] >= m2[2]) begin
        mx3 <= m2[1];
      end else begin
        mx3 <= m2[2];
      end
      for (int i = 0; i < 3; i++) begin
        tl3.amb[CW*i +: CW] <= mul_q12(eff2[i], ka2);
        tl3.dtf[CW*i +: CW] <= mul_q12(eff2[i], kd2);
        tl3.ssc[CW*i +: CW] <= ss2[i];
      end
      tl3.eye    <= eye2;
      tl3.nrm    <= nrm2;
      tl3.shin   <= shin2;
      tl3.shadow <= shadow2;
    end
  end

  // stage 4: leading one of the largest magnitude
  logic [PW-1:0] lead;
  logic          v4;
  logic [MW-1:0] m4 [3];
  logic [PW-1:0] p4;
  logic          zero4;
  logic [2:0]    sg4;
  tail_t         tl4;

  always_comb begin
    lead = '0;
    for (int b = 0; b < MW; b++) begin
      if (mx3[b]) lead = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4    <= m3;
      p4    <= lead;
      zero4 <= (mx3 == '0);
      sg4   <= sg3;
      tl4   <= tl3;
    end
  end

  // stage 5: scale so the largest magnitude sits in [2^19, 2^20)
  logic [MW+NORM_BITS-2:0] ext [3];
  logic  v5;
  side_t sd5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = {m4[i], (NORM_BITS-1)'(0)} >> p4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sd5.mag[NORM_BITS*i +: NORM_BITS] <= ext[i][NORM_BITS-1:0];
      end
      sd5.sgn  <= sg4;
      sd5.zero <= zero4;
      sd5.tail <= tl4;
    end
  end

  // stage 6: squares
  logic                   v6;
  logic [2*NORM_BITS-1:0] sq6 [3];
  side_t                  sd6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= (2*NORM_BITS)'(sd5.mag[NORM_BITS*i +: NORM_BITS])
                * (2*NORM_BITS)'(sd5.mag[NORM_BITS*i +: NORM_BITS]);
      end
      sd6 <= sd5;
    end
  end

  // stage 7: sum of squares
  logic               v7;
  logic [SUMSQ_W-1:0] sum7;
  side_t              sd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum7 <= SUMSQ_W'(sq6[0]) + SUMSQ_W'(sq6[1]) + SUMSQ_W'(sq6[2]);
      sd7  <= sd6;
    end
  end

  // length of the scaled light vector
  logic                      sq_valid;
  logic [ROOT_W-1:0]         sq_root;
  logic [$bits(side_t)-1:0]  sq_side;
  side_t                     sq_sd;

  pplsc_isqrt #(
    .SIDE_W ($bits(side_t))
  ) u_isqrt (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (v7),
    .in_radicand (sum7),
    .in_side     (sd7),
    .out_valid   (sq_valid),
    .out_root    (sq_root),
    .out_side    (sq_side)
  );

  assign sq_sd = side_t'(sq_side);

  // unit vector components: magnitude * 2^14 / length, one quotient bit a stage
  localparam int DR_W = ROOT_W + 1;

  logic [DR_W-1:0]   dr   [QUO_W][3];
  logic [QUO_W-1:0]  dq   [QUO_W][3];
  logic [ROOT_W-1:0] dlen [QUO_W];
  side_t             dsd  [QUO_W];
  logic              dv   [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [DR_W-1:0]   r_in [3];
    logic [QUO_W-1:0]  q_in [3];
    logic [ROOT_W-1:0] len_in;
    side_t             s_in;
    logic              v_in;
    logic [2:0]        ge;
    logic [DR_W-1:0]   r_sub [3];

    if (k == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign r_in[i] = DR_W'(sq_sd.mag[NORM_BITS*i +: NORM_BITS]);
        assign q_in[i] = '0;
      end
      assign len_in = sq_root;
      assign s_in   = sq_sd;
      assign v_in   = sq_valid;
    end else begin : g_next
      assign r_in   = dr[k-1];
      assign q_in   = dq[k-1];
      assign len_in = dlen[k-1];
      assign s_in   = dsd[k-1];
      assign v_in   = dv[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i]    = (r_in[i] >= DR_W'(len_in));
        r_sub[i] = ge[i] ? (r_in[i] - DR_W'(len_in)) : r_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (adv) begin
        dv[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dr[k][i] <= r_sub[i] << 1;
          dq[k][i] <= {q_in[i][QUO_W-2:0], ge[i]};
        end
        dlen[k] <= len_in;
        dsd[k]  <= s_in;
      end
    end
  end

  // stage L: signed unit light vector
  logic                    vL;
  logic signed [DIR_W-1:0] lL [3];
  tail_t                   tlL;

  always_ff @(posedge clk) begin
    if (rst) begin
      vL <= 1'b0;
    end else if (adv) begin
      vL <= dv[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (dsd[QUO_W-1].zero) begin
          lL[i] <= '0;
        end else if (dsd[QUO_W-1].sgn[i]) begin
          lL[i] <= -$signed(DIR_W'(dq[QUO_W-1][i]));
        end else begin
          lL[i] <= $signed(DIR_W'(dq[QUO_W-1][i]));
        end
      end
      tlL <= dsd[QUO_W-1].tail;
    end
  end

  // stage A: light.normal products
  logic                      vA;
  logic signed [2*DIR_W-1:0] pA [3];
  logic signed [DIR_W-1:0]   lA [3];
  tail_t                     tlA;

  always_ff @(posedge clk) begin
    if (rst) begin
      vA <= 1'b0;
    end else if (adv) begin
      vA <= vL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pA[i] <= (2*DIR_W)'(lL[i]) * (2*DIR_W)'($signed(tlL.nrm[DIR_W*i +: DIR_W]));
      end
      lA  <= lL;
      tlA <= tlL;
    end
  end

  // stage B: light.normal sum
  logic                    vB;
  logic signed [LDN_W-1:0] ldnB;
  logic signed [DIR_W-1:0] lB [3];
  tail_t                   tlB;

  always_ff @(posedge clk) begin
    if (rst) begin
      vB <= 1'b0;
    end else if (adv) begin
      vB <= vA;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ldnB <= LDN_W'(pA[0]) + LDN_W'(pA[1]) + LDN_W'(pA[2]);
      lB   <= lA;
      tlB  <= tlA;
    end
  end

  // stage C: dot product times normal, for the reflection
  localparam int PN_W = LDN_W + DIR_W;
  localparam int RF_W = PN_W - 27 + 1;

  logic                    vC;
  logic signed [PN_W-1:0]  pC [3];
  logic signed [LDN_W-1:0] ldnC;
  logic signed [DIR_W-1:0] lC [3];
  tail_t                   tlC;

  always_ff @(posedge clk) begin
    if (rst) begin
      vC <= 1'b0;
    end else if (adv) begin
      vC <= vB;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pC[i] <= PN_W'(ldnB) * PN_W'($signed(tlB.nrm[DIR_W*i +: DIR_W]));
      end
      ldnC <= ldnB;
      lC   <= lB;
      tlC  <= tlB;
    end
  end

  // stage D: reflected light vector, floor of 2*ldn*n / 2^28 minus light
  logic                    vD;
  logic signed [RF_W-1:0]  rD [3];
  logic signed [LDN_W-1:0] ldnD;
  tail_t                   tlD;

  always_ff @(posedge clk) begin
    if (rst) begin
      vD <= 1'b0;
    end else if (adv) begin
      vD <= vC;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rD[i] <= RF_W'(pC[i] >>> 27) - RF_W'(lC[i]);
      end
      ldnD <= ldnC;
      tlD  <= tlC;
    end
  end

  // stage E: reflection.eye products
  localparam int PE_W  = RF_W + DIR_W;
  localparam int RDE_W = PE_W + 2;

  logic                    vE;
  logic signed [PE_W-1:0]  pE [3];
  logic signed [LDN_W-1:0] ldnE;
  tail_t                   tlE;

  always_ff @(posedge clk) begin
    if (rst) begin
      vE <= 1'b0;
    end else if (adv) begin
      vE <= vD;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pE[i] <= PE_W'(rD[i]) * PE_W'($signed(tlD.eye[DIR_W*i +: DIR_W]));
      end
      ldnE <= ldnD;
      tlE  <= tlD;
    end
  end

  // stage F: reflection.eye sum
  logic                    vF;
  logic signed [RDE_W-1:0] rdeF;
  logic signed [LDN_W-1:0] ldnF;
  tail_t                   tlF;

  always_ff @(posedge clk) begin
    if (rst) begin
      vF <= 1'b0;
    end else if (adv) begin
      vF <= vE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdeF <= RDE_W'(pE[0]) + RDE_W'(pE[1]) + RDE_W'(pE[2]);
      ldnF <= ldnE;
      tlF  <= tlE;
    end
  end

  // stage G: term enables and clamped power base
  logic       spec_g;
  logic       vG;
  logic [POW_W-1:0] fG;
  pw_side_t   psG;

  assign spec_g = !ldnF[LDN_W-1] && !rdeF[RDE_W-1] && (rdeF != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vG <= 1'b0;
    end else if (adv) begin
      vG <= vF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!spec_g) begin
        fG <= '0;
      end else if (rdeF[RDE_W-1:POW_W+14] != '0) begin
        fG <= POW_CAP;
      end else begin
        fG <= rdeF[POW_W+13:14];
      end
      psG.spec_on <= spec_g;
      psG.dif_on  <= !tlF.shadow && !ldnF[LDN_W-1];
      psG.ldn14   <= ldnF[LDN14_W+13:14];
      psG.tail    <= tlF;
    end
  end

  // square-and-multiply power, one exponent bit a stage
  logic [POW_W-1:0] pacc [SHIN_W];
  logic [POW_W-1:0] pbase [SHIN_W];
  pw_side_t         pside [SHIN_W];
  logic             pv [SHIN_W];

  for (genvar k = 0; k < SHIN_W; k++) begin : g_pow
    logic [POW_W-1:0] acc_in;
    logic [POW_W-1:0] base_in;
    pw_side_t         s_in;
    logic             v_in;

    if (k == 0) begin : g_first
      assign acc_in  = POW_W'(Q14_ONE);
      assign base_in = fG;
      assign s_in    = psG;
      assign v_in    = vG;
    end else begin : g_next
      assign acc_in  = pacc[k-1];
      assign base_in = pbase[k-1];
      assign s_in    = pside[k-1];
      assign v_in    = pv[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[k] <= 1'b0;
      end else if (adv) begin
        pv[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pacc[k]  <= s_in.tail.shin[k] ? pow_mul(acc_in, base_in) : acc_in;
        pbase[k] <= pow_mul(base_in, base_in);
        pside[k] <= s_in;
      end
    end
  end

  // stage H: diffuse and specular products
  logic          vH;
  logic [CW-1:0] difH [3];
  logic [CW-1:0] spcH [3];
  logic [CW-1:0] ambH [3];
  logic          dif_onH, spec_onH;

  always_ff @(posedge clk) begin
    if (rst) begin
      vH <= 1'b0;
    end else if (adv) begin
      vH <= pv[SHIN_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        difH[i] <= mul_q14_d(pside[SHIN_W-1].tail.dtf[CW*i +: CW], pside[SHIN_W-1].ldn14);
        spcH[i] <= mul_q14_s(pside[SHIN_W-1].tail.ssc[CW*i +: CW], pacc[SHIN_W-1]);
        ambH[i] <= pside[SHIN_W-1].tail.amb[CW*i +: CW];
      end
      dif_onH  <= pside[SHIN_W-1].dif_on;
      spec_onH <= pside[SHIN_W-1].spec_on;
    end
  end

  // output stage: sum of terms with saturation
  logic [CW+1:0] tot [3];
  logic [CW-1:0] sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (CW+2)'(ambH[i])
             + (dif_onH ? (CW+2)'(difH[i]) : '0)
             + ((dif_onH && spec_onH) ? (CW+2)'(spcH[i]) : '0);
      sat[i] = (tot[i] > (CW+2)'(CMAX)) ? CMAX : tot[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vH;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red   <= sat[0];
      out_green <= sat[1];
      out_blue  <= sat[2];
    end
  end

  // scaled length is never below the largest scaled magnitude
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    sq_valid && !sq_sd.zero |-> sq_root >= ROOT_W'(1 << (NORM_BITS-1)))
    else $error("light vector length below scaled range");

  // unit components never exceed 1.0
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    dv[QUO_W-1] && !dsd[QUO_W-1].zero |->
      dq[QUO_W-1][0] <= QUO_W'(Q14_ONE) && dq[QUO_W-1][1] <= QUO_W'(Q14_ONE)
      && dq[QUO_W-1][2] <= QUO_W'(Q14_ONE))
    else $error("unit light component above one");

  // specular only where diffuse geometry allows it
  a_spec_gate: assert property (@(posedge clk) disable iff (rst)
    vG && psG.spec_on |-> psG.tail.shadow || psG.dif_on)
    else $error("specular enabled with negative light.normal");

endmodule

### rtl/core/pplsc_isqrt.sv
// pplsc_isqrt: pipelined integer square root, one result bit per stage
// depends on pplsc_pkg; carries an opaque sideband word alongside each item
`timescale 1ns / 1ps

module pplsc_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [pplsc_pkg::SUMSQ_W-1:0] in_radicand,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [pplsc_pkg::ROOT_W-1:0]  out_root,
  output logic [SIDE_W-1:0]             out_side
);
  import pplsc_pkg::*;

  localparam int SQ_W = SUMSQ_W + 1;

  logic [SQ_W-1:0]   xr [ROOT_W];
  logic [SQ_W-1:0]   rr [ROOT_W];
  logic              vr [ROOT_W];
  logic [SIDE_W-1:0] sr [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SQ_W-1:0]   x_in;
    logic [SQ_W-1:0]   r_in;
    logic              v_in;
    logic [SIDE_W-1:0] s_in;
    logic [SQ_W-1:0]   trial;

    if (k == 0) begin : g_first
      assign x_in = SQ_W'(in_radicand);
      assign r_in = '0;
      assign v_in = in_valid;
      assign s_in = in_side;
    end else begin : g_next
      assign x_in = xr[k-1];
      assign r_in = rr[k-1];
      assign v_in = vr[k-1];
      assign s_in = sr[k-1];
    end

    assign trial = r_in + BIT;

    // valid bit of this stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k] <= 1'b0;
      end else if (en) begin
        vr[k] <= v_in;
      end
    end

    // one restoring root step
    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in >= trial) begin
          xr[k] <= x_in - trial;
          rr[k] <= (r_in >> 1) + BIT;
        end else begin
          xr[k] <= x_in;
          rr[k] <= r_in >> 1;
        end
        sr[k] <= s_in;
      end
    end
  end

  assign out_valid = vr[ROOT_W-1];
  assign out_root  = rr[ROOT_W-1][ROOT_W-1:0];
  assign out_side  = sr[ROOT_W-1];

endmodule

### tb/phong_point_light_shader_core_tb.sv
// phong_point_light_shader_core_tb: self-checking bench for the phong point light shader core
// depends on pplsc_pkg and phong_point_light_shader_core; predicts each shaded colour in-bench
`timescale 1ns / 1ps

module phong_point_light_shader_core_tb;
  import pplsc_pkg::*;

  localparam int CW = 24;
  localparam int KW = 16;
  localparam int DW = (CW > KW) ? CW : KW;
  localparam longint KMAX = 65535;
  localparam longint PCAP = 64'd16777215;
  localparam int LATENCY = 63;

  typedef struct packed {
    logic [CW-1:0] px, py, pz;
    logic [47:0]   eye, nrm, col, coef;
    logic [9:0]    shin;
    logic          shadow;
  } hit_t;

  typedef struct packed {
    logic [KW-1:0] r, g, b;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [47:0] eye_dir = '0, normal_dir = '0, surface_colour = '0, material_coeffs = '0;
  logic [9:0] shininess = '0;
  logic in_shadow = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [KW-1:0] out_red, out_green, out_blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;

  // light state mirrored in the bench
  logic signed [CW-1:0] lpos [3];
  logic [KW-1:0] lint [3];

  rgb_t shade_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always #10 clk = ~clk;

  phong_point_light_shader_core u_top (.*);

  // integer square root, floor
  function automatic longint root_floor(longint x);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint shr_floor(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-v + (64'sd1 <<< k) - 1) >>> k);
  endfunction

  function automatic longint cap_k(longint v);
    return (v > KMAX) ? KMAX : v;
  endfunction

  function automatic longint cap_p(longint v);
    return (v > PCAP) ? PCAP : v;
  endfunction

  // q14 power by square and multiply
  function automatic longint spec_power(longint f, int e);
    longint acc;
    acc = Q14_ONE;
    f = cap_p(f);
    while (e != 0) begin
      if (e & 1) acc = cap_p((acc * f) >>> 14);
      f = cap_p((f * f) >>> 14);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic rgb_t shade_point(hit_t h);
    longint d[3], m[3], lv[3], nv[3], ev[3];
    longint mx, sumsq, len, ldn, rde, ldn14, f, rr, col, eff, sum, t, s, ka, kd, ks;
    logic [KW-1:0] o[3];
    bit spec_on;
    rgb_t res;
    d[0] = longint'(lpos[0]) - longint'($signed(h.px));
    d[1] = longint'(lpos[1]) - longint'($signed(h.py));
    d[2] = longint'(lpos[2]) - longint'($signed(h.pz));
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (d[i] < 0) ? -d[i] : d[i];
      if (m[i] > mx) mx = m[i];
      ev[i] = longint'($signed(h.eye[16*i +: 16]));
      nv[i] = longint'($signed(h.nrm[16*i +: 16]));
    end
    // unit light vector, zero when light sits on the point
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) lv[i] = 0;
    end else begin
      while (mx >= (64'sd1 <<< 20)) begin
        mx = mx >>> 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
      end
      while (mx < (64'sd1 <<< 19)) begin
        mx = mx <<< 1;
        for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
      end
      sumsq = 0;
      for (int i = 0; i < 3; i++) sumsq += m[i] * m[i];
      len = root_floor(sumsq);
      for (int i = 0; i < 3; i++) lv[i] = (d[i] < 0) ? -((m[i] <<< 14) / len)
                                                      : ((m[i] <<< 14) / len);
    end
    ldn = 0;
    for (int i = 0; i < 3; i++) ldn += lv[i] * nv[i];
    ldn14 = shr_floor(ldn, 14);
    rde = 0;
    for (int i = 0; i < 3; i++) begin
      rr = -lv[i] + shr_floor(2 * ldn * nv[i], 28);
      rde += rr * ev[i];
    end
    spec_on = (ldn >= 0) && (rde > 0);
    f = spec_on ? spec_power(rde >>> 14, h.shin) : 0;
    ka = h.coef[15:0];
    kd = h.coef[31:16];
    ks = h.coef[47:32];
    for (int i = 0; i < 3; i++) begin
      col = h.col[16*i +: 16];
      eff = cap_k((col * lint[i]) >>> 12);
      sum = cap_k((eff * ka) >>> 12);
      if (!h.shadow && ldn >= 0) begin
        t = cap_k((eff * kd) >>> 12);
        sum += cap_k((t * ldn14) >>> 14);
        if (spec_on) begin
          s = cap_k((longint'(lint[i]) * ks) >>> 12);
          sum += cap_k((s * f) >>> 14);
        end
      end
      o[i] = cap_k(sum);
    end
    res.r = o[0];
    res.g = o[1];
    res.b = o[2];
    return res;
  endfunction

  // random idle on the result side
  always @(posedge clk) begin
    result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (shade_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item r=%h g=%h b=%h", $time, out_red, out_green, out_blue);
      end else begin
        want = shade_q.pop_front();
        if (want.r !== out_red) begin
          errors++;
          $display("%0t: red expected %h actual %h", $time, want.r, out_red);
        end
        if (want.g !== out_green) begin
          errors++;
          $display("%0t: green expected %h actual %h", $time, want.g, out_green);
        end
        if (want.b !== out_blue) begin
          errors++;
          $display("%0t: blue expected %h actual %h", $time, want.b, out_blue);
        end
      end
    end
  end

  // one item through the handshake, with a random gap first
  task automatic send_hit(hit_t h);
    while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct)) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    point_x <= h.px;
    point_y <= h.py;
    point_z <= h.pz;
    eye_dir <= h.eye;
    normal_dir <= h.nrm;
    surface_colour <= h.col;
    material_coeffs <= h.coef;
    shininess <= h.shin;
    in_shadow <= h.shadow;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    shade_q.insert(shade_q.size(), shade_point(h));
    n_items++;
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LIGHT_POS_X: lpos[0] = val[CW-1:0];
      REG_LIGHT_POS_Y: lpos[1] = val[CW-1:0];
      REG_LIGHT_POS_Z: lpos[2] = val[CW-1:0];
      REG_LIGHT_RED:   lint[0] = val[KW-1:0];
      REG_LIGHT_GREEN: lint[1] = val[KW-1:0];
      default:         lint[2] = val[KW-1:0];
    endcase
  endtask

  task automatic set_light(logic [CW-1:0] x, y, z, logic [KW-1:0] r, g, b);
    write_reg(REG_LIGHT_POS_X, DW'(x));
    write_reg(REG_LIGHT_POS_Y, DW'(y));
    write_reg(REG_LIGHT_POS_Z, DW'(z));
    write_reg(REG_LIGHT_RED, DW'(r));
    write_reg(REG_LIGHT_GREEN, DW'(g));
    write_reg(REG_LIGHT_BLUE, DW'(b));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_dir_comp();
    case ($urandom_range(3))
      0: return 16'(Q14_ONE);
      1: return -16'(Q14_ONE);
      2: return 16'($urandom_range(65535));
      default: return 16'($signed($urandom_range(2 * Q14_ONE)) - Q14_ONE);
    endcase
  endfunction

  // mostly near-unit vectors and modest coefficients, full-range colours, some raw noise
  function automatic hit_t rand_hit();
    hit_t h;
    bit wild;
    wild = ($urandom_range(9) == 0);
    h.px = wild ? CW'($urandom) : CW'($signed($urandom_range(65535)) - 32768);
    h.py = wild ? CW'($urandom) : CW'($signed($urandom_range(65535)) - 32768);
    h.pz = wild ? CW'($urandom) : CW'($signed($urandom_range(65535)) - 32768);
    h.eye = wild ? 48'({$urandom, $urandom})
                 : {rand_dir_comp(), rand_dir_comp(), rand_dir_comp()};
    h.nrm = wild ? 48'({$urandom, $urandom})
                 : {rand_dir_comp(), rand_dir_comp(), rand_dir_comp()};
    h.col = 48'({$urandom, $urandom});
    h.coef = wild ? 48'({$urandom, $urandom})
                  : {16'($urandom_range(8191)), 16'($urandom_range(8191)),
                     16'($urandom_range(8191))};
    h.shin = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(64));
    h.shadow = ($urandom_range(4) == 0);
    return h;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_hit(rand_hit());
  endtask

  // extremes and special cases under the reset light
  task automatic test_directed;
    hit_t h;
    h = '0;
    h.nrm = {16'd0, 16'd0, 16'(Q14_ONE)};
    h.eye = h.nrm;
    h.col = {3{16'h1000}};
    h.coef = {3{16'h1000}};
    send_hit(h);                            // light on the point
    h.px = -24'sd4096;
    send_hit(h);                            // head-on light, shininess zero
    h.shin = 10'd1023;
    send_hit(h);
    h.shadow = 1'b1;
    send_hit(h);
    h.shadow = 1'b0;
    h.nrm = {16'd0, 16'd0, -16'(Q14_ONE)};
    send_hit(h);                            // light behind the surface
    h.col = '1;
    h.coef = '1;
    h.nrm = {16'd0, 16'd0, 16'(Q14_ONE)};
    h.shin = 10'd1;
    send_hit(h);                            // saturation
    h.px = 24'h800000;
    h.py = 24'h7fffff;
    h.pz = 24'h800000;
    h.eye = '1;
    h.nrm = {3{16'h7fff}};
    send_hit(h);                            // coordinate extremes, non-unit vectors
    h.px = 24'h7fffff;
    h.eye = {3{16'h8000}};
    h.nrm = {3{16'h8000}};
    send_hit(h);
    h.eye = {16'h5555, 16'haaaa, 16'h5555};
    h.nrm = {16'haaaa, 16'h5555, 16'haaaa};
    h.shin = 10'h2aa;
    send_hit(h);
    h.shin = 10'h155;
    h.col = '0;
    send_hit(h);
    drain();
  endtask

  task automatic test_light_extremes;
    set_light(24'h7fffff, 24'h800000, 24'h7fffff, 16'hffff, 16'h0000, 16'hffff);
    run_random(150);
    drain();
    set_light(24'h800000, 24'h7fffff, 24'h000001, 16'h0000, 16'hffff, 16'h0001);
    run_random(150);
    drain();
  endtask

  task automatic test_idle_phases;
    set_light(24'h010000, 24'h020000, 24'h040000, 16'h1800, 16'h0c00, 16'h1000);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(385);
    send_idle_pct = 65;
    run_random(385);
    drain();                                // sender holds off until all results are in
    send_idle_pct = 0;
    stall_pct = 65;
    run_random(385);
    send_idle_pct = 13;
    stall_pct = 13;
    run_random(385);
    stall_pct = 0;
    send_idle_pct = 0;
    drain();
  endtask

  initial begin
    lpos[0] = '0;
    lpos[1] = '0;
    lpos[2] = '0;
    for (int i = 0; i < 3; i++) lint[i] = 16'(LIGHT_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_light_extremes();
    test_idle_phases();
    $display("shaded %0d items (%0d results) across light extremes, shadowing and idle mixes",
             n_items, n_results);
    if (errors == 0) begin
      $display("phong_point_light_shader_core: match");
    end else begin
      $display("phong_point_light_shader_core: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("phong_point_light_shader_core: mismatch");
    $finish;
  end

endmodule
